### sv/mahd_pkg.sv
package mahd_pkg;

  localparam int unsigned DivSteps = 24;
  localparam int unsigned StepW    = $clog2(DivSteps);

  localparam logic [7:0]  SyncByte       = 8'hFF;
  localparam logic [1:0]  VerReserved    = 2'd1;
  localparam logic [1:0]  VerMpeg1       = 2'd3;
  localparam logic [1:0]  LayerReserved  = 2'd0;
  localparam logic [1:0]  LayerOne       = 2'd3;
  localparam logic [3:0]  BidxReserved   = 4'd15;
  localparam logic [1:0]  FidxReserved   = 2'd3;
  localparam logic [10:0] SyncPattern    = 11'h7FF;
  localparam logic [15:0] SlotScaleLayer1 = 16'd12000;
  localparam logic [15:0] SlotScaleOther  = 16'd36000;

  localparam logic [8:0] RateTable [2][3][16] = '{
    '{
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}
    },
    '{
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}
    }
  };

  localparam logic [15:0] FreqTable [4][3] = '{
    '{11025, 12000, 8000},
    '{0, 0, 0},
    '{22050, 24000, 16000},
    '{44100, 48000, 32000}
  };

  typedef struct packed {
    logic first_load;
    logic shift_load;
    logic hdr_load;
    logic mul_load;
    logic div_step;
    logic out_load;
  } mahd_cmd_t;

  typedef struct packed {
    logic sync_byte;
    logic restart;
  } mahd_sts_t;

  function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                input logic [1:0] layer,
                                                input logic [3:0] bidx);
    logic [8:0] r;
    logic       row;
    logic [1:0] col;
    r   = '0;
    row = (ver != VerMpeg1);
    col = layer - 2'd1;
    if (ver != VerReserved && layer != LayerReserved) begin
      r = RateTable[row][col][bidx];
    end
    return r;
  endfunction

  function automatic logic [15:0] freq_lookup(input logic [1:0] ver,
                                              input logic [1:0] fidx);
    logic [15:0] r;
    r = '0;
    if (fidx != FidxReserved) begin
      r = FreqTable[ver][fidx];
    end
    return r;
  endfunction

endpackage

### sv/mahd_in_if.sv
interface mahd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       restart;

  modport source(output valid, output stream_byte, output restart, input ready);
  modport sink(input valid, input stream_byte, input restart, output ready);
endinterface

### sv/mahd_out_if.sv
interface mahd_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic [1:0]  version_code;
  logic [1:0]  layer_code;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [1:0]  channel_mode;
  logic [1:0]  mode_extension;
  logic [1:0]  emphasis_code;
  logic [4:0]  flag_bits;
  logic [9:0]  frame_slots;

  modport source(output valid, output header_ok, output version_code, output layer_code,
                 output bitrate_kbps, output sample_rate_hz, output channel_mode,
                 output mode_extension, output emphasis_code, output flag_bits,
                 output frame_slots, input ready);
  modport sink(input valid, input header_ok, input version_code, input layer_code,
               input bitrate_kbps, input sample_rate_hz, input channel_mode,
               input mode_extension, input emphasis_code, input flag_bits,
               input frame_slots, output ready);
endinterface

### sv/mahd_ctrl.sv
module mahd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mahd_pkg::mahd_sts_t sts_i,
  output mahd_pkg::mahd_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic                       searching_q, searching_d;
  logic [1:0]                 count_q, count_d;
  logic [mahd_pkg::StepW-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  logic                       in_fire;
  logic                       srch;
  logic [1:0]                 cnt;

  // a final header byte waits until the previous result reaches the output register
  assign in_ready_o  = !(!searching_q && count_q == 2'd3 && state_q != StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    searching_d = searching_q;
    count_d     = count_q;
    step_d      = step_q;
    srch        = searching_q | sts_i.restart;
    cnt         = sts_i.restart ? 2'd0 : count_q;

    case (state_q)
      StIdle: begin
      end
      StMul: begin
        cmd_o.mul_load = 1'b1;
        step_d         = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == mahd_pkg::StepW'(mahd_pkg::DivSteps - 1)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (in_fire) begin
      if (srch) begin
        if (sts_i.sync_byte) begin
          cmd_o.first_load = 1'b1;
          searching_d      = 1'b0;
          count_d          = 2'd1;
        end else begin
          searching_d = 1'b1;
          count_d     = 2'd0;
        end
      end else if (cnt == 2'd3) begin
        cmd_o.hdr_load = 1'b1;
        searching_d    = 1'b1;
        count_d        = 2'd0;
        state_d        = StMul;
      end else begin
        cmd_o.shift_load = 1'b1;
        count_d          = cnt + 2'd1;
      end
    end

    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      searching_q <= 1'b1;
      count_q     <= 2'd0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      searching_q <= searching_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/mahd_dp.sv
module mahd_dp (
  input  logic                clk_i,
  input  logic [7:0]          stream_byte_i,
  input  logic                restart_i,
  input  mahd_pkg::mahd_cmd_t cmd_i,
  output mahd_pkg::mahd_sts_t sts_o,
  output logic                header_ok_o,
  output logic [1:0]          version_code_o,
  output logic [1:0]          layer_code_o,
  output logic [8:0]          bitrate_kbps_o,
  output logic [15:0]         sample_rate_hz_o,
  output logic [1:0]          channel_mode_o,
  output logic [1:0]          mode_extension_o,
  output logic [1:0]          emphasis_code_o,
  output logic [4:0]          flag_bits_o,
  output logic [9:0]          frame_slots_o
);

  logic [23:0] shift_q;
  logic [31:0] hdr_q;
  logic [8:0]  bitrate_q;
  logic [15:0] freq_q;
  logic [23:0] dvd_q;
  logic [15:0] rem_q;

  logic [1:0]  ver, layer, fidx;
  logic [3:0]  bidx;
  logic        ok;
  logic [15:0] scale;
  logic [24:0] product;
  logic [16:0] trial;
  logic [17:0] diff;
  logic        ge;
  logic [9:0]  slots;

  logic        out_ok_q;
  logic [1:0]  out_ver_q, out_layer_q, out_chan_q, out_mext_q, out_emph_q;
  logic [8:0]  out_bitrate_q;
  logic [15:0] out_freq_q;
  logic [4:0]  out_flags_q;
  logic [9:0]  out_slots_q;

  assign sts_o.sync_byte = (stream_byte_i == mahd_pkg::SyncByte);
  assign sts_o.restart   = restart_i;

  assign ver   = hdr_q[20:19];
  assign layer = hdr_q[18:17];
  assign bidx  = hdr_q[15:12];
  assign fidx  = hdr_q[11:10];
  assign ok    = (hdr_q[31:21] == mahd_pkg::SyncPattern) && (ver != mahd_pkg::VerReserved)
              && (layer != mahd_pkg::LayerReserved) && (bidx != mahd_pkg::BidxReserved)
              && (fidx != mahd_pkg::FidxReserved);

  // frame length numerator: 12 or 36 times bitrate times 1000
  assign scale   = (layer == mahd_pkg::LayerOne) ? mahd_pkg::SlotScaleLayer1
                                                 : mahd_pkg::SlotScaleOther;
  assign product = mahd_pkg::bitrate_lookup(ver, layer, bidx) * scale;

  // restoring divider, one quotient bit per step
  assign trial = {rem_q, dvd_q[23]};
  assign diff  = {1'b0, trial} - {2'b00, freq_q};
  assign ge    = !diff[17];
  assign slots = ok ? (dvd_q[9:0] + {9'd0, hdr_q[9]}) : 10'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.first_load) begin
      shift_q <= {16'd0, stream_byte_i};
    end else if (cmd_i.shift_load) begin
      shift_q <= {shift_q[15:0], stream_byte_i};
    end
    if (cmd_i.hdr_load) begin
      hdr_q <= {shift_q, stream_byte_i};
    end
    if (cmd_i.mul_load) begin
      bitrate_q <= mahd_pkg::bitrate_lookup(ver, layer, bidx);
      freq_q    <= (ver != mahd_pkg::VerReserved) ? mahd_pkg::freq_lookup(ver, fidx) : 16'd0;
      dvd_q     <= product[23:0];
      rem_q     <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[22:0], ge};
      rem_q <= ge ? diff[15:0] : trial[15:0];
    end
    if (cmd_i.out_load) begin
      out_ok_q      <= ok;
      out_ver_q     <= ver;
      out_layer_q   <= layer;
      out_bitrate_q <= bitrate_q;
      out_freq_q    <= freq_q;
      out_chan_q    <= hdr_q[7:6];
      out_mext_q    <= hdr_q[5:4];
      out_emph_q    <= hdr_q[1:0];
      out_flags_q   <= {hdr_q[2], hdr_q[3], hdr_q[8], hdr_q[9], hdr_q[16]};
      out_slots_q   <= slots;
    end
  end

  assign header_ok_o      = out_ok_q;
  assign version_code_o   = out_ver_q;
  assign layer_code_o     = out_layer_q;
  assign bitrate_kbps_o   = out_bitrate_q;
  assign sample_rate_hz_o = out_freq_q;
  assign channel_mode_o   = out_chan_q;
  assign mode_extension_o = out_mext_q;
  assign emphasis_code_o  = out_emph_q;
  assign flag_bits_o      = out_flags_q;
  assign frame_slots_o    = out_slots_q;

endmodule

### sv/mpeg_audio_header_decoder_core.sv
// Scans a byte stream for 0xFF, gathers that byte and the next three into a 32-bit
// header and returns one decoded result per header. Bytes are taken one per cycle
// unless a fourth header byte is held back. Once the fourth byte of a header is
// taken, the frame length is worked out by a multiply step and a 24-step
// bit-serial divider, and the result is loaded into the output register once that
// register is free. Bytes keep flowing meanwhile; only the fourth byte of a
// following header waits until the previous result has been loaded into the
// output register.
module mpeg_audio_header_decoder_core (
  input logic        clk_i,
  input logic        rst_ni,
  mahd_in_if.sink    in_i,
  mahd_out_if.source out_o
);

  mahd_pkg::mahd_cmd_t cmd;
  mahd_pkg::mahd_sts_t sts;

  mahd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mahd_dp u_dp (
    .clk_i            (clk_i),
    .stream_byte_i    (in_i.stream_byte),
    .restart_i        (in_i.restart),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .header_ok_o      (out_o.header_ok),
    .version_code_o   (out_o.version_code),
    .layer_code_o     (out_o.layer_code),
    .bitrate_kbps_o   (out_o.bitrate_kbps),
    .sample_rate_hz_o (out_o.sample_rate_hz),
    .channel_mode_o   (out_o.channel_mode),
    .mode_extension_o (out_o.mode_extension),
    .emphasis_code_o  (out_o.emphasis_code),
    .flag_bits_o      (out_o.flag_bits),
    .frame_slots_o    (out_o.frame_slots)
  );

endmodule
